### src/ose_pkg.sv
// shared types and constants of the odometer string enumerator
`default_nettype none

package ose_pkg;

    // fixed field widths
    localparam int REQ_W      = 2;
    localparam int SYM_IDX_W  = 6;
    localparam int CHAR_W     = 8;
    localparam int CPOS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ASIZE_W    = 7;
    localparam int LEN_CFG_W  = 5;
    localparam int COUNT_W    = 32;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_NEXT    = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_WRITE   = 2'd2
    } ose_req_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT     = 2'd3;

    // configuration reset values
    localparam logic [ASIZE_W-1:0]   ALPHABET_SIZE_RST = 7'd26;
    localparam logic [LEN_CFG_W-1:0] MIN_LENGTH_RST    = 5'd1;
    localparam logic [LEN_CFG_W-1:0] MAX_LENGTH_RST    = 5'd8;
    localparam logic [COUNT_W-1:0]   MAX_COUNT_RST     = 32'hFFFF_FFFF;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DONE
    } ose_state_t;

    // controller to datapath
    typedef struct packed {
        logic restart;
        logic wr_sym;
        logic start_emit;
        logic issue_char;
        logic issue_done;
    } ose_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic exhausted;
        logic last_pos;
        logic out_free;
    } ose_status_t;

endpackage

`default_nettype wire

### src/ose_ctrl.sv
// controller state machine of the odometer string enumerator
`default_nettype none

module ose_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic [ose_pkg::REQ_W-1:0]      req_type,
    input  wire ose_pkg::ose_status_t           status,
    output ose_pkg::ose_cmd_t                   cmd
);
    import ose_pkg::*;

    ose_state_t state_reg;
    ose_state_t state_next;
    logic       take;

    assign take = (state_reg == ST_IDLE) && req_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (req_type == REQ_NEXT))
                begin
                    state_next = status.exhausted ? ST_DONE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.last_pos)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall      = (state_reg != ST_IDLE);
        cmd.restart    = take && (req_type == REQ_RESTART);
        cmd.wr_sym     = take && (req_type == REQ_WRITE);
        cmd.start_emit = take && (req_type == REQ_NEXT) && !status.exhausted;
        cmd.issue_char = (state_reg == ST_EMIT) && status.out_free;
        cmd.issue_done = (state_reg == ST_DONE) && status.out_free;
    end

endmodule

`default_nettype wire

### src/ose_datapath.sv
// datapath: config registers, odometer digits, alphabet memory, result register
`default_nettype none

module ose_datapath #(
    parameter int MAX_LEN        = 16,
    parameter int ALPHABET_DEPTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ose_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ose_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [ose_pkg::SYM_IDX_W-1:0]     symbol_index,
    input  wire logic [ose_pkg::CHAR_W-1:0]        symbol_code,
    input  wire ose_pkg::ose_cmd_t                 cmd,
    output ose_pkg::ose_status_t                   status,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [ose_pkg::CHAR_W-1:0]             char_code,
    output logic [ose_pkg::CPOS_W-1:0]             char_position,
    output logic                                   is_last,
    output logic                                   done_res
);
    import ose_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DW = $clog2(ALPHABET_DEPTH);
    localparam int SW = $clog2(ALPHABET_DEPTH + 1);

    // configuration
    logic [ASIZE_W-1:0]   alphabet_size_reg;
    logic [LEN_CFG_W-1:0] min_length_reg;
    logic [LEN_CFG_W-1:0] max_length_reg;
    logic [COUNT_W-1:0]   max_count_reg;

    // enumeration state
    logic [DW-1:0]      digit_reg  [MAX_LEN];
    logic [DW-1:0]      digit_next [MAX_LEN];
    logic [LW-1:0]      length_reg, length_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               finished_reg, finished_next;
    logic               carry_reg, carry_next;
    logic [PW-1:0]      pos_reg, pos_next;

    // alphabet memory and result stage
    logic [CHAR_W-1:0]  alphabet_mem [ALPHABET_DEPTH];
    logic [CHAR_W-1:0]  rd_data_reg;
    logic               out_valid_reg;
    logic [CPOS_W-1:0]  out_pos_reg;
    logic               out_last_reg;
    logic               out_done_reg;

    logic [SW-1:0]      eff_size;
    logic [LW-1:0]      eff_min, eff_max, eff_hi;
    logic [DW-1:0]      cur_digit;
    logic [DW:0]        digit_inc;
    logic               wraps;

    function automatic logic [LW-1:0] clamp_len(input logic [LEN_CFG_W-1:0] v);
        logic [LW-1:0] r;
        if (v == '0)
        begin
            r = LW'(1);
        end
        else if (int'(v) > MAX_LEN)
        begin
            r = LW'(MAX_LEN);
        end
        else
        begin
            r = LW'(v);
        end
        return r;
    endfunction

    // effective limits
    always_comb
    begin
        if (alphabet_size_reg == '0)
        begin
            eff_size = SW'(1);
        end
        else if (int'(alphabet_size_reg) > ALPHABET_DEPTH)
        begin
            eff_size = SW'(ALPHABET_DEPTH);
        end
        else
        begin
            eff_size = SW'(alphabet_size_reg);
        end
        eff_min = clamp_len(min_length_reg);
        eff_hi  = clamp_len(max_length_reg);
        eff_max = (eff_hi < eff_min) ? eff_min : eff_hi;
    end

    assign cur_digit = digit_reg[pos_reg];
    assign digit_inc = {1'b0, cur_digit} + (DW+1)'(1);
    assign wraps     = !(digit_inc < (DW+1)'(eff_size));

    assign status.exhausted = finished_reg || (count_reg >= max_count_reg)
                              || (length_reg > eff_max);
    assign status.last_pos  = ((LW'(pos_reg) + LW'(1)) == length_reg);
    assign status.out_free  = !out_valid_reg || !res_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_size_reg <= ALPHABET_SIZE_RST;
            min_length_reg    <= MIN_LENGTH_RST;
            max_length_reg    <= MAX_LENGTH_RST;
            max_count_reg     <= MAX_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHABET_SIZE: alphabet_size_reg <= cfg_wdata[ASIZE_W-1:0];
                CFG_MIN_LENGTH:    min_length_reg    <= cfg_wdata[LEN_CFG_W-1:0];
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_wdata[LEN_CFG_W-1:0];
                CFG_MAX_COUNT:     max_count_reg     <= cfg_wdata[COUNT_W-1:0];
                default:           max_count_reg     <= max_count_reg;
            endcase
        end
    end

    // odometer step: one position per issued character, carry rippling upward
    always_comb
    begin
        digit_next    = digit_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        carry_next    = carry_reg;
        pos_next      = pos_reg;
        if (cmd.restart)
        begin
            for (int i = 0; i < MAX_LEN; i++)
            begin
                digit_next[i] = '0;
            end
            length_next   = eff_min;
            count_next    = '0;
            finished_next = 1'b0;
        end
        else if (cmd.start_emit)
        begin
            pos_next   = '0;
            carry_next = 1'b1;
        end
        else if (cmd.issue_char)
        begin
            if (carry_reg)
            begin
                digit_next[pos_reg] = wraps ? '0 : digit_inc[DW-1:0];
                carry_next          = wraps;
            end
            if (status.last_pos)
            begin
                count_next = count_reg + COUNT_W'(1);
                // carry out of the top digit; every digit is already zero
                if (carry_reg && wraps)
                begin
                    if (length_reg < eff_max)
                    begin
                        length_next = length_reg + LW'(1);
                    end
                    else
                    begin
                        finished_next = 1'b1;
                    end
                end
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEN; i++)
            begin
                digit_reg[i] <= '0;
            end
            length_reg   <= LW'(1);
            count_reg    <= '0;
            finished_reg <= 1'b0;
            carry_reg    <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            digit_reg    <= digit_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
            carry_reg    <= carry_next;
            pos_reg      <= pos_next;
        end
    end

    // alphabet memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_sym && (int'(symbol_index) < ALPHABET_DEPTH))
        begin
            alphabet_mem[DW'(symbol_index)] <= symbol_code;
        end
        if (cmd.issue_char)
        begin
            rd_data_reg <= alphabet_mem[cur_digit];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.issue_char || cmd.issue_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue_char)
        begin
            out_pos_reg  <= CPOS_W'(pos_reg);
            out_last_reg <= status.last_pos;
            out_done_reg <= 1'b0;
        end
        else if (cmd.issue_done)
        begin
            out_pos_reg  <= '0;
            out_last_reg <= 1'b1;
            out_done_reg <= 1'b1;
        end
    end

    assign res_valid     = out_valid_reg;
    assign char_code     = out_done_reg ? '0 : rd_data_reg;
    assign char_position = out_pos_reg;
    assign is_last       = out_last_reg;
    assign done_res      = out_done_reg;

endmodule

`default_nettype wire

### src/odometer_string_enumerator.sv
// top level of the odometer string enumerator
// usage:
//   request channel (req_valid/req_stall) carries one transaction per request:
//   next candidate, restart, or alphabet symbol write (symbol_index, symbol_code)
//   result channel (res_valid/res_stall) returns one transaction per character
//   of the current candidate, position 0 first, is_last on the final one; a
//   next request after the keyspace or max_count is used up returns a single
//   transaction with done_res and is_last set and zero char_code/char_position
//   timing: a candidate is issued one character per cycle while res_stall is low,
//   paced by the single read port of the alphabet memory; once the request is
//   taken the controller enters its emit state, and the first character is then
//   registered into the result register; restart and symbol writes return nothing
//   req_stall stays high while a candidate or done result is still being issued
//   a stalled result holds; issue pauses behind it and resumes when it leaves
//   reset: config back to defaults (26 symbols, lengths 1..8, max_count all ones),
//   odometer at length 1 with all digits zero; alphabet entries hold garbage
//   until written
//   config writes (cfg_we/cfg_index/cfg_wdata) belong in idle periods only
`default_nettype none

module odometer_string_enumerator #(
    parameter int MAX_LEN        = 16,
    parameter int ALPHABET_DEPTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [ose_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ose_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request channel
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic [ose_pkg::REQ_W-1:0]         req_type,
    input  wire logic [ose_pkg::SYM_IDX_W-1:0]     symbol_index,
    input  wire logic [ose_pkg::CHAR_W-1:0]        symbol_code,
    // result channel
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [ose_pkg::CHAR_W-1:0]             char_code,
    output logic [ose_pkg::CPOS_W-1:0]             char_position,
    output logic                                   is_last,
    output logic                                   done_res
);
    import ose_pkg::*;

    ose_cmd_t    cmd;
    ose_status_t status;

    // sequencing: request decode, per-character issue, done result
    ose_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .status    (status),
        .cmd       (cmd)
    );

    // odometer digits, counters, alphabet memory and result register
    ose_datapath #(
        .MAX_LEN        (MAX_LEN),
        .ALPHABET_DEPTH (ALPHABET_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .symbol_index  (symbol_index),
        .symbol_code   (symbol_code),
        .cmd           (cmd),
        .status        (status),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .char_code     (char_code),
        .char_position (char_position),
        .is_last       (is_last),
        .done_res      (done_res)
    );

endmodule

`default_nettype wire

### src/ose_checker.sv
// port-level checker of the odometer string enumerator and its bind
`default_nettype none

module ose_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_stall,
    input wire logic [ose_pkg::REQ_W-1:0]         req_type,
    input wire logic                              res_valid,
    input wire logic                              res_stall,
    input wire logic [ose_pkg::CHAR_W-1:0]        char_code,
    input wire logic [ose_pkg::CPOS_W-1:0]        char_position,
    input wire logic                              is_last,
    input wire logic                              done_res
);
    import ose_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(char_code)
            && $stable(char_position) && $stable(is_last) && $stable(done_res))
        else $error("stalled result changed");

    // a done result is a lone, last, zero transaction
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> is_last && (char_code == '0)
            && (char_position == '0))
        else $error("malformed done result");

    // a taken next request always leaves the block busy in the following cycle
    a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_type == REQ_NEXT) |=> req_stall)
        else $error("next request did not occupy the block");

    // mid-candidate the request side stays closed
    a_mid_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_last |-> req_stall)
        else $error("request taken during a candidate");

endmodule

bind odometer_string_enumerator ose_checker u_ose_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .char_code     (char_code),
    .char_position (char_position),
    .is_last       (is_last),
    .done_res      (done_res)
);

`default_nettype wire
